// ===== sv/d3q27_equilibrium_distribution_assert.svh =====
// Assertion macros shared by the equilibrium generator modules.
`ifndef D3Q27_EQUILIBRIUM_DISTRIBUTION_ASSERT_SVH
`define D3Q27_EQUILIBRIUM_DISTRIBUTION_ASSERT_SVH

// same-cycle implication
`define D3Q_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define D3Q_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define D3Q_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// ===== sv/d3q_pkg.sv =====
// Shared types, lattice tables and constants for the D3Q27 equilibrium generator.
package d3q_pkg;

  localparam int NUM_DIRS = 27;
  localparam int DIR_W    = 5;
  localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(NUM_DIRS - 1);

  // lattice velocity components, one per direction
  localparam logic signed [1:0] LAT_EX [NUM_DIRS] = '{
    2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1,
    -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1,
    2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] LAT_EY [NUM_DIRS] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
    -2'sd1, 2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, -2'sd1,
    2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] LAT_EZ [NUM_DIRS] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1,
    2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1,
    2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

  // weights are 2^shift / 216: rest 64, face 16, edge 4, corner 1
  localparam logic [2:0] WSH_REST   = 3'd6;
  localparam logic [2:0] WSH_FACE   = 3'd4;
  localparam logic [2:0] WSH_EDGE   = 3'd2;
  localparam logic [2:0] WSH_CORNER = 3'd0;
  localparam logic [DIR_W-1:0] LAST_FACE = DIR_W'(6);
  localparam logic [DIR_W-1:0] LAST_EDGE = DIR_W'(18);

  // floor(a / 27) = (a * RECIP27) >> RECIP_SHIFT, exact for a < 2^31
  localparam int RECIP_SHIFT = 36;
  localparam logic [31:0] RECIP27 = 32'd2545165806;

  typedef struct packed {
    logic             vld;
    logic [DIR_W-1:0] dir;
    logic             last;
  } tag_t;

  function automatic logic [2:0] weight_shift(input logic [DIR_W-1:0] dir);
    logic [2:0] sh;
    if (dir == '0) begin
      sh = WSH_REST;
    end else if (dir <= LAST_FACE) begin
      sh = WSH_FACE;
    end else if (dir <= LAST_EDGE) begin
      sh = WSH_EDGE;
    end else begin
      sh = WSH_CORNER;
    end
    return sh;
  endfunction

endpackage

// ===== sv/d3q27_equilibrium_distribution.sv =====
// Top level of the D3Q27 lattice Boltzmann equilibrium generator.
// Usage:
//   Input: drive density, temperature and vel_x/y/z with start high; the cell
//   is taken at a rising edge where start is high and busy is low.
//   Output: 27 results per cell in direction order 0..26, each shown for one
//   cycle with valid high; last marks direction 26. Results are Q11.20,
//   momentum_eq = w*rho*(1+3cu+4.5cu^2-1.5u^2), thermal_eq = w*T*(1+3cu),
//   rounded to nearest with ties away from zero.
// Timing:
//   The sequencer issues one direction per cycle into an eight-stage datapath;
//   busy falls in the cycle of a cell's last issue and a new cell can follow
//   directly, so the directions of successive cells issue back to back.
// Reset:
//   rst (synchronous) empties the sequencer and clears all valid bits.
// Stalls:
//   The receiver cannot stall; every valid cycle delivers one result.
module d3q27_equilibrium_distribution (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [15:0]               density,
  input  logic signed [17:0]        temperature,
  input  logic signed [14:0]        vel_x,
  input  logic signed [14:0]        vel_y,
  input  logic signed [14:0]        vel_z,
  output logic                      valid,
  output logic [d3q_pkg::DIR_W-1:0] direction,
  output logic signed [31:0]        momentum_eq,
  output logic signed [31:0]        thermal_eq,
  output logic                      last
);

  d3q_pkg::tag_t      issue;
  logic [15:0]        rho;
  logic signed [17:0] temp;
  logic signed [14:0] ux, uy, uz;

  d3q_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .density     (density),
    .temperature (temperature),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .issue       (issue),
    .rho         (rho),
    .temp        (temp),
    .ux          (ux),
    .uy          (uy),
    .uz          (uz)
  );

  d3q_eq_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .rho         (rho),
    .temp        (temp),
    .ux          (ux),
    .uy          (uy),
    .uz          (uz),
    .valid       (valid),
    .direction   (direction),
    .momentum_eq (momentum_eq),
    .thermal_eq  (thermal_eq),
    .last        (last)
  );

endmodule

// ===== sv/d3q_seq.sv =====
// Item capture and direction sequencer: issues 27 directions per accepted cell.
`include "d3q27_equilibrium_distribution_assert.svh"

module d3q_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         density,
  input  logic signed [17:0]  temperature,
  input  logic signed [14:0]  vel_x,
  input  logic signed [14:0]  vel_y,
  input  logic signed [14:0]  vel_z,
  output d3q_pkg::tag_t       issue,
  output logic [15:0]         rho,
  output logic signed [17:0]  temp,
  output logic signed [14:0]  ux,
  output logic signed [14:0]  uy,
  output logic signed [14:0]  uz
);

  logic                        active;
  logic [d3q_pkg::DIR_W-1:0]   dir;
  logic                        accept;

  // a new item may be taken in the cycle that issues the last direction
  assign busy   = active && (dir != d3q_pkg::LAST_DIR);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dir    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      dir    <= '0;
    end else if (active) begin
      if (dir == d3q_pkg::LAST_DIR) begin
        active <= 1'b0;
      end else begin
        dir <= dir + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rho  <= density;
      temp <= temperature;
      ux   <= vel_x;
      uy   <= vel_y;
      uz   <= vel_z;
    end
  end

  assign issue.vld  = active;
  assign issue.dir  = dir;
  assign issue.last = active && (dir == d3q_pkg::LAST_DIR);

  `D3Q_ASSERT_NXT(a_dir_step, issue.vld && !issue.last,
                  issue.vld && issue.dir == $past(issue.dir) + 1'b1,
                  "direction run broken")
  `D3Q_ASSERT_NXT(a_accept_restart, start && !busy, issue.vld && issue.dir == '0,
                  "accepted item did not start at direction 0")
  `D3Q_ASSERT_IMP(a_busy_active, busy, issue.vld, "busy without a run in progress")
  `D3Q_ASSERT_ALWAYS(a_dir_range, issue.dir <= d3q_pkg::LAST_DIR, "direction out of range")

endmodule

// ===== sv/d3q_div27.sv =====
// Signed truncating quotient stage: registered multiply by the reciprocal of 27.
module d3q_div27 (
  input  logic               clk,
  input  logic [30:0]        a,
  input  logic               neg,
  output logic signed [31:0] res
);

  logic [62:0] prod;
  logic        neg_q;
  logic [26:0] q;

  always_ff @(posedge clk) begin
    prod  <= a * d3q_pkg::RECIP27;
    neg_q <= neg;
  end

  assign q   = prod[d3q_pkg::RECIP_SHIFT +: 27];
  // magnitude stays below 2^27, so the Q11.20 range is never reached
  assign res = neg_q ? -$signed({5'b0, q}) : $signed({5'b0, q});

endmodule

// ===== sv/d3q_eq_pipe.sv =====
// Eight-stage equilibrium datapath: one direction enters per cycle.
`include "d3q27_equilibrium_distribution_assert.svh"

module d3q_eq_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  d3q_pkg::tag_t             issue,
  input  logic [15:0]               rho,
  input  logic signed [17:0]        temp,
  input  logic signed [14:0]        ux,
  input  logic signed [14:0]        uy,
  input  logic signed [14:0]        uz,
  output logic                      valid,
  output logic [d3q_pkg::DIR_W-1:0] direction,
  output logic signed [31:0]        momentum_eq,
  output logic signed [31:0]        thermal_eq,
  output logic                      last
);

  localparam logic signed [36:0] BR_ONE   = 37'sd536870912;  // 2.0 in units 2^-28
  localparam logic signed [18:0] LIN_ONE  = 19'sd16384;
  localparam logic [42:0]        T_HALF   = 43'd27648;       // half of 216 << 8
  localparam logic [57:0]        M_HALF   = 58'd905969664;   // half of 216 << 23

  function automatic logic signed [16:0] lat_term(input logic signed [1:0] e,
                                                  input logic signed [14:0] u);
    logic signed [16:0] ue;
    ue = {{2{u[14]}}, u};
    if (e == 2'sd1) begin
      return ue;
    end else if (e == -2'sd1) begin
      return -ue;
    end else begin
      return '0;
    end
  endfunction

  d3q_pkg::tag_t s1_tag, s2_tag, s3_tag, s4_tag, s5_tag, s6_tag, s7_tag;

  // stage 1
  logic signed [16:0] cu_c;
  logic signed [29:0] sqx_c, sqy_c, sqz_c;
  logic signed [16:0] s1_cu;
  logic [28:0]        s1_sqx, s1_sqy, s1_sqz;
  logic [2:0]         s1_wsh;
  logic [15:0]        s1_rho;
  logic signed [17:0] s1_temp;
  // stage 2
  logic signed [33:0] cu2_c;
  logic signed [18:0] cu19_c;
  logic [31:0]        s2_cu2;
  logic [29:0]        s2_u2;
  logic signed [16:0] s2_cu;
  logic signed [18:0] s2_lin;
  logic [2:0]         s2_wsh;
  logic [15:0]        s2_rho;
  logic signed [17:0] s2_temp;
  // stage 3
  logic signed [36:0] cu37_c, br_c, tl_c;
  logic signed [35:0] s3_br;
  logic signed [36:0] s3_tl;
  logic [15:0]        s3_rho;
  logic [2:0]         s3_wsh;
  // stage 4
  logic [33:0]        pl_c;
  logic signed [34:0] ph_c;
  logic signed [42:0] pt_c;
  logic [42:0]        magt_c, roundt_c;
  logic [33:0]        s4_pl;
  logic signed [34:0] s4_ph;
  logic [2:0]         s4_wsh;
  logic [30:0]        s4_at;
  logic               s4_tneg;
  // stage 5
  logic signed [52:0] rb_c;
  logic signed [51:0] s5_rb;
  logic [2:0]         s5_wsh;
  logic signed [31:0] g5;
  // stage 6
  logic signed [57:0] pm_c;
  logic [57:0]        magm_c, roundm_c;
  logic [30:0]        s6_am;
  logic               s6_mneg;
  logic signed [31:0] s6_g;
  // stage 7
  logic signed [31:0] f7;
  logic signed [31:0] s7_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag    <= '0;
      s2_tag    <= '0;
      s3_tag    <= '0;
      s4_tag    <= '0;
      s5_tag    <= '0;
      s6_tag    <= '0;
      s7_tag    <= '0;
      valid     <= 1'b0;
      direction <= '0;
      last      <= 1'b0;
    end else begin
      s1_tag    <= issue;
      s2_tag    <= s1_tag;
      s3_tag    <= s2_tag;
      s4_tag    <= s3_tag;
      s5_tag    <= s4_tag;
      s6_tag    <= s5_tag;
      s7_tag    <= s6_tag;
      valid     <= s7_tag.vld;
      direction <= s7_tag.dir;
      last      <= s7_tag.last;
    end
  end

  // stage 1: lattice dot product and velocity squares
  always_comb begin
    cu_c = lat_term(d3q_pkg::LAT_EX[issue.dir], ux)
         + lat_term(d3q_pkg::LAT_EY[issue.dir], uy)
         + lat_term(d3q_pkg::LAT_EZ[issue.dir], uz);
    sqx_c = ux * ux;
    sqy_c = uy * uy;
    sqz_c = uz * uz;
  end

  // stage 2: cu^2, u^2, 1 + 3cu
  always_comb begin
    cu2_c  = s1_cu * s1_cu;
    cu19_c = {{2{s1_cu[16]}}, s1_cu};
  end

  // stage 3: 2*(1 + 3cu + 4.5cu^2 - 1.5u^2) in units 2^-28, and T*(1 + 3cu)
  always_comb begin
    cu37_c = {{20{s2_cu[16]}}, s2_cu};
    br_c   = BR_ONE + cu37_c * 37'sd98304 + $signed({5'b0, s2_cu2}) * 37'sd9
           - $signed({7'b0, s2_u2}) * 37'sd3;
    tl_c   = s2_temp * s2_lin;
  end

  // stage 4: rho*br split in two partial products; thermal weight and rounding
  always_comb begin
    pl_c     = s3_rho * s3_br[17:0];
    ph_c     = $signed({1'b0, s3_rho}) * $signed(s3_br[35:18]);
    pt_c     = {{6{s3_tl[36]}}, s3_tl} <<< s3_wsh;
    magt_c   = pt_c[42] ? -pt_c : pt_c;
    roundt_c = magt_c + T_HALF;
  end

  // stage 5: recombine partials
  assign rb_c = ({{18{s4_ph[34]}}, s4_ph} <<< 18) + $signed({19'b0, s4_pl});

  // stage 6: momentum weight and rounding
  always_comb begin
    pm_c     = {{6{s5_rb[51]}}, s5_rb} <<< s5_wsh;
    magm_c   = pm_c[57] ? -pm_c : pm_c;
    roundm_c = magm_c + M_HALF;
  end

  always_ff @(posedge clk) begin
    s1_cu   <= cu_c;
    s1_sqx  <= sqx_c[28:0];
    s1_sqy  <= sqy_c[28:0];
    s1_sqz  <= sqz_c[28:0];
    s1_wsh  <= d3q_pkg::weight_shift(issue.dir);
    s1_rho  <= rho;
    s1_temp <= temp;

    s2_cu2  <= cu2_c[31:0];
    s2_u2   <= {1'b0, s1_sqx} + {1'b0, s1_sqy} + {1'b0, s1_sqz};
    s2_cu   <= s1_cu;
    s2_lin  <= LIN_ONE + cu19_c * 19'sd3;
    s2_wsh  <= s1_wsh;
    s2_rho  <= s1_rho;
    s2_temp <= s1_temp;

    s3_br   <= br_c[35:0];
    s3_tl   <= tl_c;
    s3_rho  <= s2_rho;
    s3_wsh  <= s2_wsh;

    s4_pl   <= pl_c;
    s4_ph   <= ph_c;
    s4_wsh  <= s3_wsh;
    s4_at   <= roundt_c[41:11];
    s4_tneg <= pt_c[42];

    s5_rb   <= rb_c[51:0];
    s5_wsh  <= s4_wsh;

    s6_am   <= roundm_c[56:26];
    s6_mneg <= pm_c[57];
    s6_g    <= g5;

    s7_g    <= s6_g;

    momentum_eq <= f7;
    thermal_eq  <= s7_g;
  end

  d3q_div27 u_div_t (
    .clk (clk),
    .a   (s4_at),
    .neg (s4_tneg),
    .res (g5)
  );

  d3q_div27 u_div_m (
    .clk (clk),
    .a   (s6_am),
    .neg (s6_mneg),
    .res (f7)
  );

  `D3Q_ASSERT_IMP(a_last_dir, valid && last, direction == d3q_pkg::LAST_DIR,
                  "last mark away from the final direction")
  `D3Q_ASSERT_NXT(a_run_order, valid && !last,
                  valid && direction == $past(direction) + 1'b1,
                  "result run broken before its last item")
  `D3Q_ASSERT_IMP(a_run_cont, valid && direction != '0, $past(valid),
                  "run resumed after a gap")

endmodule
